>>> sv/assert_macros.svh
// Assertion macros shared by the chunky-to-planar RTL.
// Sampled on clk; the first form is masked while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define C2P_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("c2p assertion failed");
`define C2P_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("c2p assertion failed");
`else
`define C2P_ASSERT(lbl, prop)
`define C2P_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/c2p_pkg.sv
// Shared types and constants for the chunky-to-planar converter.
// No dependencies.
package c2p_pkg;

  localparam int unsigned PLANE_SLOTS = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] FIRST_BIT = 8'h80;
  localparam logic [7:0] LAST_BIT  = 8'h01;

  typedef enum logic [0:0] {
    CFG_PLANE_COUNT = 1'b0,
    CFG_ROW_PIXELS  = 1'b1
  } cfg_idx_t;

  // One finished group on its way to the serializer.
  typedef struct packed {
    logic [PLANE_SLOTS-1:0][7:0] acc;
    logic [3:0]                  planes;
    logic [8:0]                  col;
  } c2p_grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } c2p_qstat_t;

endpackage

>>> sv/c2p_front.sv
// Front end: takes pixels, shifts their bits into the plane accumulators
// and pushes each finished group with at least one plane into the queue. Uses c2p_pkg.
`include "assert_macros.svh"

module c2p_front #(
  parameter int unsigned MAX_PLANES = 8,
  parameter int unsigned CW         = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_pixel_value,
  input  logic [3:0]          planes,
  input  logic [CW:0]         row_lim,
  output logic                push,
  output c2p_pkg::c2p_grp_t   push_grp,
  input  c2p_pkg::c2p_qstat_t qstat
);
  import c2p_pkg::*;

  logic [7:0]    acc_r     [MAX_PLANES];
  logic [7:0]    acc_nxt   [MAX_PLANES];
  logic [7:0]    merged    [MAX_PLANES];
  logic [2:0]    bitpos_r, bitpos_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW+8:0] col_ext;
  logic [7:0]    mask;
  logic          accept;
  logic          row_end;
  logic          grp_end;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mask    = FIRST_BIT >> bitpos_r;
    row_end = ({1'b0, col_r} + {{CW{1'b0}}, 1'b1}) >= row_lim;
    grp_end = (bitpos_r == 3'd7) || row_end;
    col_ext = (CW+9)'(col_r);
    for (int k = 0; k < MAX_PLANES; k++) begin
      merged[k] = acc_r[k];
      if ((4'(k) < planes) && in_pixel_value[k]) begin
        merged[k] = acc_r[k] | mask;
      end
    end

    push            = accept && grp_end && (planes != 4'd0);
    push_grp        = '0;
    push_grp.planes = planes;
    push_grp.col    = col_ext[11:3];
    for (int k = 0; k < MAX_PLANES; k++) begin
      push_grp.acc[k] = merged[k];
    end

    for (int k = 0; k < MAX_PLANES; k++) begin
      acc_nxt[k] = acc_r[k];
      if (accept) begin
        acc_nxt[k] = grp_end ? 8'h00 : merged[k];
      end
    end
    bitpos_nxt = bitpos_r;
    col_nxt    = col_r;
    if (accept) begin
      bitpos_nxt = grp_end ? 3'd0 : bitpos_r + 3'd1;
      col_nxt    = row_end ? '0 : col_r + {{(CW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PLANES; k++) begin
        acc_r[k] <= 8'h00;
      end
      bitpos_r <= 3'd0;
      col_r    <= '0;
    end else begin
      for (int k = 0; k < MAX_PLANES; k++) begin
        acc_r[k] <= acc_nxt[k];
      end
      bitpos_r <= bitpos_nxt;
      col_r    <= col_nxt;
    end
  end

  `C2P_ASSERT(a_push_not_full, push |-> !qstat.full)
  `C2P_ASSERT(a_group_restart, (accept && grp_end) |=> (bitpos_r == 3'd0))
  `C2P_ASSERT(a_bit_advance, (accept && !grp_end) |=> (bitpos_r == 3'($past(bitpos_r) + 3'd1)))

endmodule

>>> sv/c2p_queue.sv
// Short group queue between front and back ends.
// Register storage, QUEUE_DEPTH entries from c2p_pkg.
`include "assert_macros.svh"

module c2p_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  c2p_pkg::c2p_grp_t   push_grp,
  input  logic                pop,
  output c2p_pkg::c2p_grp_t   head,
  output c2p_pkg::c2p_qstat_t qstat
);
  import c2p_pkg::*;

  c2p_grp_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    head        = mem_r[rd_r];
    qstat.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
    qstat.empty = (cnt_r == '0);
    wr_nxt  = push ? (wr_r + QPTR_W'(1)) : wr_r;
    rd_nxt  = pop  ? (rd_r + QPTR_W'(1)) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `C2P_ASSERT(a_pop_not_empty, pop |-> !qstat.empty)
  `C2P_ASSERT(a_cnt_bound, cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH))
  `C2P_ASSERT(a_cnt_drop, (pop && !push) |=> (cnt_r == ($past(cnt_r) - (QPTR_W+1)'(1))))

endmodule

>>> sv/c2p_back.sv
// Back end: walks the planes of the queue head and sends one plane byte
// per cycle through the output register while out_stall is low. Uses c2p_pkg.
`include "assert_macros.svh"

module c2p_back (
  input  logic                clk,
  input  logic                rst_n,
  input  c2p_pkg::c2p_grp_t   head,
  input  c2p_pkg::c2p_qstat_t qstat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_plane_byte,
  output logic [2:0]          out_plane_number,
  output logic [8:0]          out_byte_column,
  output logic                out_last_of_group
);
  import c2p_pkg::*;

  logic       vld_r, vld_nxt;
  logic [2:0] k_r, k_nxt;
  logic [7:0] byte_r;
  logic [2:0] pnum_r;
  logic [8:0] col_r;
  logic       last_r;
  logic       load;
  logic       last;

  always_comb begin
    load    = !qstat.empty && (!vld_r || !out_stall);
    last    = ({1'b0, k_r} + 4'd1) == head.planes;
    pop     = load && last;
    k_nxt   = k_r;
    if (load) begin
      k_nxt = last ? 3'd0 : k_r + 3'd1;
    end
    vld_nxt = load ? 1'b1 : (vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= 3'd0;
    end else begin
      vld_r <= vld_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.acc[k_r];
      pnum_r <= k_r;
      col_r  <= head.col;
      last_r <= last;
    end
  end

  assign out_valid         = vld_r;
  assign out_plane_byte    = byte_r;
  assign out_plane_number  = pnum_r;
  assign out_byte_column   = col_r;
  assign out_last_of_group = last_r;

  `C2P_ASSERT(a_head_has_planes, load |-> (head.planes != 4'd0))
  `C2P_ASSERT(a_plane_step, (load && !last) |=> (k_r == 3'($past(k_r) + 3'd1)))
  `C2P_ASSERT(a_pop_rewinds, pop |=> (k_r == 3'd0))

endmodule

>>> sv/chunky_to_planar_pixels.sv
// Chunky-to-planar converter top level: config registers, front end,
// group queue and back end. Uses c2p_pkg, c2p_front, c2p_queue, c2p_back.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+--------------------------------------
//   in      | in_valid  | in_stall  | in_pixel_value
//   out     | out_valid | out_stall | out_plane_byte, out_plane_number,
//           |           |           | out_byte_column, out_last_of_group
//   cfg     | cfg_we    | -         | cfg_index, cfg_wdata
//
// One pixel item is accepted per cycle while in_stall is low; a group end
// with at least one plane pushes the group into a four-entry queue. The back
// end sends one plane byte per cycle while out_stall is low, one per plane.
// in_stall rises only while the queue is full. Reset is synchronous and
// clears all control state at once; no clearing pass is needed.
module chunky_to_planar_pixels #(
  parameter int unsigned MAX_PLANES     = 8,
  parameter int unsigned MAX_ROW_PIXELS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_pixel_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_plane_byte,
  output logic [2:0]        out_plane_number,
  output logic [8:0]        out_byte_column,
  output logic              out_last_of_group,
  input  logic              cfg_we,
  input  c2p_pkg::cfg_idx_t cfg_index,
  input  logic [12:0]       cfg_wdata
);
  import c2p_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ROW_PIXELS);
  localparam int unsigned WW = (CW + 1 > 13) ? CW + 1 : 13;

  logic [3:0]  plane_count_r, plane_count_nxt;
  logic [12:0] row_pixels_r, row_pixels_nxt;
  logic [3:0]  planes;
  logic [WW-1:0] row_w, row_sat;
  logic [CW:0] row_lim;

  logic       push;
  logic       pop;
  c2p_grp_t   push_grp;
  c2p_grp_t   head;
  c2p_qstat_t qstat;

  always_comb begin
    plane_count_nxt = plane_count_r;
    row_pixels_nxt  = row_pixels_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PLANE_COUNT: plane_count_nxt = cfg_wdata[3:0];
        CFG_ROW_PIXELS:  row_pixels_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= 4'd8;
      row_pixels_r  <= 13'd320;
    end else begin
      plane_count_r <= plane_count_nxt;
      row_pixels_r  <= row_pixels_nxt;
    end
  end

  // Effective limits: plane count and row length saturate, row length of zero means one.
  always_comb begin
    planes = (plane_count_r > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : plane_count_r;
    row_w  = WW'(row_pixels_r);
    if (row_w == '0) begin
      row_sat = WW'(1);
    end else if (row_w > WW'(MAX_ROW_PIXELS)) begin
      row_sat = WW'(MAX_ROW_PIXELS);
    end else begin
      row_sat = row_w;
    end
    row_lim = row_sat[CW:0];
  end

  c2p_front #(
    .MAX_PLANES (MAX_PLANES),
    .CW         (CW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .planes         (planes),
    .row_lim        (row_lim),
    .push           (push),
    .push_grp       (push_grp),
    .qstat          (qstat)
  );

  c2p_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  c2p_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .qstat             (qstat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_plane_byte    (out_plane_byte),
    .out_plane_number  (out_plane_number),
    .out_byte_column   (out_byte_column),
    .out_last_of_group (out_last_of_group)
  );

endmodule

>>> sim/chunky_to_planar_pixels_test.sv
// Self-checking testbench for chunky_to_planar_pixels: a plane packing predictor,
// a pixel driver, random output stalls and an in-order result checker.
// Depends on c2p_pkg and the chunky_to_planar_pixels RTL.
`timescale 1ns / 100ps

module chunky_to_planar_pixels_test;
  import c2p_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct {
    logic [7:0] byte_val;
    logic [2:0] plane;
    logic [8:0] column;
    logic       last;
  } plane_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_pixel_value = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_plane_byte;
  logic [2:0]  out_plane_number;
  logic [8:0]  out_byte_column;
  logic        out_last_of_group;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_PLANE_COUNT;
  logic [12:0] cfg_wdata = 13'h0;

  // predictor state
  logic [3:0]  plane_limit = 4'd8;
  logic [12:0] row_limit = 13'd320;
  logic [7:0]  plane_acc [8];
  int unsigned bit_slot = 0;
  int unsigned pixel_column = 0;

  plane_result_t plane_bytes_due[$];

  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned plane_bytes_seen = 0;
  int unsigned mismatch_count = 0;
  bit          idle_on = 1'b1;
  bit          holding = 1'b0;
  int unsigned hold_req = 0;
  int unsigned stall_left = 0;

  chunky_to_planar_pixels DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plane_byte   (out_plane_byte),
    .out_plane_number (out_plane_number),
    .out_byte_column  (out_byte_column),
    .out_last_of_group(out_last_of_group),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d plane bytes outstanding",
               cycle_count, plane_bytes_due.size());
      $display("chunky_to_planar_pixels: mismatch");
      $finish;
    end
  end

  // Folds one accepted pixel into the plane accumulators, queues the bytes due.
  function automatic void pack_pixel(logic [7:0] px);
    int unsigned   planes;
    int unsigned   row;
    logic [7:0]    mask;
    logic          row_end;
    plane_result_t r;
    planes = (plane_limit > 8) ? 8 : plane_limit;
    row = (row_limit == 0) ? 1 : ((row_limit > 4096) ? 4096 : row_limit);
    mask = FIRST_BIT >> bit_slot;
    for (int k = 0; k < planes; k++)
      if (px[k]) plane_acc[k] = plane_acc[k] | mask;
    row_end = (pixel_column + 1 >= row);
    if (mask == LAST_BIT || row_end) begin
      for (int k = 0; k < planes; k++) begin
        r.byte_val = plane_acc[k];
        r.plane = k[2:0];
        r.column = pixel_column[11:3];
        r.last = (k + 1 == planes);
        plane_bytes_due.push_back(r);
      end
      for (int k = 0; k < 8; k++) plane_acc[k] = 8'h00;
      bit_slot = 0;
    end else begin
      bit_slot = bit_slot + 1;
    end
    pixel_column = row_end ? 0 : pixel_column + 1;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(input logic [7:0] px);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= px;
    do @(posedge clk); while (in_stall);
    pack_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Stops the source, waits for every expected plane byte, then lets the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (plane_bytes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_PLANE_COUNT) plane_limit = val[3:0];
    else row_limit = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Output side: random stall bursts, or a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holding) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        holding = 1'b1;
        repeat (hold_req) @(posedge clk);
        holding = 1'b0;
        hold_req = 0;
      end
    end
  end

  always @(posedge clk) begin
    plane_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      plane_bytes_seen++;
      if (plane_bytes_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected plane byte %02h plane %0d col %0d last %0b",
                   out_plane_byte, out_plane_number, out_byte_column, out_last_of_group);
      end else begin
        exp_r = plane_bytes_due.pop_front();
        if (out_plane_byte !== exp_r.byte_val || out_plane_number !== exp_r.plane ||
            out_byte_column !== exp_r.column || out_last_of_group !== exp_r.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("bad plane byte: expected %02h/%0d/%0d/%0b, got %02h/%0d/%0d/%0b",
                     exp_r.byte_val, exp_r.plane, exp_r.column, exp_r.last,
                     out_plane_byte, out_plane_number, out_byte_column, out_last_of_group);
        end
      end
    end
  end

  // Reset values: eight planes, 320-pixel rows.
  task automatic test_default_config();
    logic [7:0] pixels [10] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA,
                                8'h55, 8'h0F, 8'hF0, 8'hC3, 8'h3C};
    for (int i = 0; i < 10; i++) send_pixel(pixels[i]);
    wait_drained();
  endtask

  // Single plane, one-pixel rows, zero planes, zero and oversized rows, saturation.
  task automatic test_register_extremes();
    write_reg(CFG_PLANE_COUNT, 13'd1);
    write_reg(CFG_ROW_PIXELS, 13'd1);
    send_pixel(8'hFF);
    send_pixel(8'hFE);
    wait_drained();
    write_reg(CFG_PLANE_COUNT, 13'd0);
    write_reg(CFG_ROW_PIXELS, 13'd0);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    wait_drained();
    write_reg(CFG_PLANE_COUNT, 13'h1FFF);  // only the low four bits count
    write_reg(CFG_ROW_PIXELS, 13'd3);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h81);
    wait_drained();
    write_reg(CFG_PLANE_COUNT, 13'd8);
    write_reg(CFG_ROW_PIXELS, 13'd8191);
    send_pixel(8'h7E);
    send_pixel(8'hBD);
    wait_drained();
  endtask

  // Row length shrunk behind the current column; plane count changed inside a group.
  task automatic test_mid_row_changes();
    write_reg(CFG_ROW_PIXELS, 13'd20);
    for (int i = 0; i < 12; i++) send_pixel(8'($urandom_range(0, 255)));
    wait_drained();
    write_reg(CFG_ROW_PIXELS, 13'd5);
    send_pixel(8'hFF);
    send_pixel(8'h33);
    send_pixel(8'hCC);
    wait_drained();
    write_reg(CFG_PLANE_COUNT, 13'd3);
    send_pixel(8'hFF);
    send_pixel(8'h5A);
    wait_drained();
    write_reg(CFG_PLANE_COUNT, 13'd6);
    write_reg(CFG_ROW_PIXELS, 13'd16);
    for (int i = 0; i < 6; i++) send_pixel(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  // Longest row on one plane; byte columns climb through the first groups.
  task automatic test_long_row();
    write_reg(CFG_PLANE_COUNT, 13'd1);
    write_reg(CFG_ROW_PIXELS, 13'd4096);
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  // Receiver holds off while every pixel ends a group; the group queue fills.
  task automatic test_backpressure();
    idle_on = 1'b0;
    write_reg(CFG_PLANE_COUNT, 13'd8);
    write_reg(CFG_ROW_PIXELS, 13'd1);
    hold_req = 300;
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(0, 255)));
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    logic [12:0] val;
    sent = 0;
    while (sent < 120) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) val = 13'($urandom_range(1, 8));
      else if (pick == 8) val = 13'd0;
      else val = 13'($urandom_range(9, 15));
      if ($urandom_range(0, 3) == 0) val[12:4] = 9'($urandom_range(0, 511));
      write_reg(CFG_PLANE_COUNT, val);
      pick = $urandom_range(0, 9);
      if (pick < 7) val = 13'($urandom_range(1, 24));
      else if (pick < 9) val = 13'($urandom_range(25, 600));
      else val = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(4096, 8191));
      write_reg(CFG_ROW_PIXELS, val);
      n = $urandom_range(16, 56);
      for (int i = 0; i < n; i++) send_pixel(8'($urandom_range(0, 255)));
      sent += n;
      wait_drained();
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_reg(CFG_PLANE_COUNT, 13'd8);
    write_reg(CFG_ROW_PIXELS, 13'd24);
    for (int i = 0; i < 64; i++) send_pixel(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  initial begin
    for (int k = 0; k < 8; k++) plane_acc[k] = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_config();
    test_register_extremes();
    test_mid_row_changes();
    test_long_row();
    test_backpressure();
    test_random_frames();
    test_steady_stream();
    mismatch_count += plane_bytes_due.size();
    $display("sent %0d pixels and checked %0d plane bytes", pixels_sent, plane_bytes_seen);
    $display("covered 0..15 planes, rows 0..8191, mid-row changes and a full-queue stall");
    if (mismatch_count == 0) begin
      $display("chunky_to_planar_pixels: match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("chunky_to_planar_pixels: mismatch");
    end
    $finish;
  end

endmodule
